// ===== hw/rtl/msk_block_phase_estimator_unit_assert.svh =====
// assertion macros shared by the rtl files
`ifndef MSK_BLOCK_PHASE_ESTIMATOR_UNIT_ASSERT_SVH
`define MSK_BLOCK_PHASE_ESTIMATOR_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define MBPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define MBPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mbpe_pkg.sv =====
`default_nettype none
package mbpe_pkg;

    localparam int MAX_AVERAGE_DEF  = 1024;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ANGLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int SUM_W   = 28;
    localparam int CW      = 40;   // cordic datapath width
    localparam int PH_W    = 16;
    localparam int LEN_W   = 11;
    localparam int REF_W   = 16;

    localparam logic [CW-1:0] ROT_START = CW'(10188014);

    localparam logic [1:0] OP_VEC = 2'd0;
    localparam logic [1:0] OP_ROT = 2'd1;

    // config register indexes
    localparam logic [0:0] REG_MODE = 1'b0;
    localparam logic [0:0] REG_LEN  = 1'b1;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } cordic_cmd_t;

    function automatic logic [31:0] arc_at(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'd536870912;
                5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;
                5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;
                5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;
                5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;
                5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mbpe_cordic.sv =====
`default_nettype none
module mbpe_cordic #(
    parameter int CORDIC_STEPS = mbpe_pkg::CORDIC_STEPS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  mbpe_pkg::cordic_cmd_t        cmd,
    input  wire signed [mbpe_pkg::CW-1:0] x_in,
    input  wire signed [mbpe_pkg::CW-1:0] y_in,
    input  wire        [31:0]            z_in,
    output logic                         done,
    output logic signed [mbpe_pkg::CW-1:0] x_out,
    output logic signed [mbpe_pkg::CW-1:0] y_out,
    output logic       [31:0]            z_out
);
    import mbpe_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam logic [4:0] LAST = 5'(NSTEP - 1);

    logic              busy_reg, busy_next;
    logic [1:0]        op_reg, op_next;
    logic [4:0]        idx_reg, idx_next;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic [31:0]       z_reg, z_next;
    logic              done_reg, done_next;

    logic signed [CW-1:0] xs, ys;
    logic                 dir_up;
    logic [31:0]          arc;

    // one micro-rotation per cycle
    always_comb
    begin
        xs = x_reg >>> idx_reg;
        ys = y_reg >>> idx_reg;
        arc = arc_at(idx_reg);
        if (op_reg == OP_VEC)
            dir_up = (y_reg > 0);
        else
            dir_up = !z_reg[31];
        busy_next = busy_reg;
        op_next = op_reg;
        idx_next = idx_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next = cmd.op;
            idx_next = '0;
            x_next = x_in;
            y_next = y_in;
            z_next = z_in;
        end
        else if (busy_reg)
        begin
            if (dir_up)
            begin
                // vectoring with y>0, or rotation with z>=0
                if (op_reg == OP_VEC)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + arc;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - arc;
                end
            end
            else
            begin
                if (op_reg == OP_VEC)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - arc;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + arc;
                end
            end
            idx_next = idx_reg + 5'd1;
            if (idx_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            op_reg   <= OP_VEC;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

`include "msk_block_phase_estimator_unit_assert.svh"
    `MBPE_ASSERT_IMP(a_no_restart, clk, rst_n, busy_reg, !cmd.start, "cordic restarted while busy")
    `MBPE_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg, "done held two cycles")
    `MBPE_ASSERT_IMP(a_idx_range, clk, rst_n, busy_reg, idx_reg <= LAST, "step index out of range")

endmodule
`default_nettype wire

// ===== hw/rtl/msk_block_phase_estimator_unit.sv =====
// channel | dir | handshake      | payload
// in      | in  | valid / stall  | sample_real, sample_imag, reference_phase, reference_valid
// out     | out | valid / stall  | phase, block_error
// cfg     | in  | valid / ready  | cfg_index, cfg_data
//
// each sample uses one shared cordic: vector then rotate (a zero sample skips the vector pass)
// a block end adds a vectoring of the sums unless both sums are zero
// a skipped sample does not use the cordic; the shared cordic is the limiting unit
// reset clears the sums, block count, unwrap state, error flag, sequencer and config registers
// in_stall is high while a sample is being worked and while a result waits
`default_nettype none
module msk_block_phase_estimator_unit #(
    parameter int MAX_AVERAGE  = mbpe_pkg::MAX_AVERAGE_DEF,
    parameter int SAMPLE_WIDTH = mbpe_pkg::SAMPLE_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = mbpe_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = mbpe_pkg::CORDIC_STEPS_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire signed [15:0]               sample_real,
    input  wire signed [15:0]               sample_imag,
    input  wire signed [15:0]               reference_phase,
    input  wire                             reference_valid,
    output logic                            out_valid,
    input  wire                             out_stall,
    output logic signed [15:0]              phase,
    output logic                            block_error,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire        [0:0]                cfg_index,
    input  wire        [mbpe_pkg::LEN_W-1:0] cfg_data
);
    import mbpe_pkg::*;

    localparam int CNT_W = (MAX_AVERAGE > 1) ? $clog2(MAX_AVERAGE) : 1;
    localparam logic [16:0] MAXL = 17'(MAX_AVERAGE);
    localparam logic [CNT_W:0] CNT_MAX = (CNT_W+1)'(MAX_AVERAGE);

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_VEC1  = 3'd1;
    localparam logic [2:0] S_ROT   = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_BEND  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]   st_reg, st_next;
    logic         mode_reg;
    logic [LEN_W-1:0] len_reg;
    logic signed [SUM_W-1:0] ss_reg, ss_next, sc_reg, sc_next;
    logic [CNT_W:0] cnt_reg, cnt_next;
    logic signed [ANGLE_WIDTH-1:0] prev_reg, prev_next;
    logic         par_reg, par_next;
    logic [REF_W-1:0] ref_reg;
    logic         vld_reg;
    logic signed [SAMPLE_WIDTH-1:0] re_reg, im_reg;
    logic [15:0]  ph_reg, ph_next;
    logic         err_reg, err_next;

    cordic_cmd_t  cmd;
    logic signed [CW-1:0] cx_in, cy_in, cx, cy;
    logic [31:0]  cz_in, cz;
    logic         cdone;

    logic [16:0]  len_eff;
    logic signed [SUM_W+1:0] add_c, add_s;
    logic signed [CW-1:0] rc, rs;
    logic [31:0]  vang, p32, half;
    logic signed [ANGLE_WIDTH-1:0] pq;
    logic signed [ANGLE_WIDTH:0] dlt;
    logic         sum_zero, last_smp, use_smp;

    // config only when idle and no sample is offered in the same cycle
    assign cfg_ready = (st_reg == S_IDLE) && !in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            len_reg  <= LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE: mode_reg <= cfg_data[0];
                REG_LEN:  len_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    mbpe_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .x_in(cx_in), .y_in(cy_in), .z_in(cz_in),
        .done(cdone), .x_out(cx), .y_out(cy), .z_out(cz)
    );

    // round a 32 bit angle to the output width
    function automatic logic signed [ANGLE_WIDTH-1:0] to_ang(input logic [31:0] a);
        logic [31:0] r;
        begin
            r = a + (32'd1 << (31 - ANGLE_WIDTH));
            return r[31 -: ANGLE_WIDTH];
        end
    endfunction

    function automatic logic signed [SUM_W-1:0] sat(input logic signed [SUM_W+1:0] v);
        logic signed [SUM_W+1:0] mx, mn;
        begin
            mx = (SUM_W+2)'((1 << (SUM_W-1)) - 1);
            mn = -mx - (SUM_W+2)'(1);
            if (v > mx) return mx[SUM_W-1:0];
            else if (v < mn) return mn[SUM_W-1:0];
            else return v[SUM_W-1:0];
        end
    endfunction

    always_comb
    begin
        len_eff = {6'd0, len_reg};
        if (len_eff == 17'd0) len_eff = 17'd1;
        if (len_eff > MAXL) len_eff = MAXL;
        last_smp = ({{(16-CNT_W){1'b0}}, cnt_reg} + 17'd1 >= len_eff);
        use_smp = mode_reg || vld_reg;
        sum_zero = (ss_reg == '0) && (sc_reg == '0);
        rc = (cx + CW'(128)) >>> 8;
        rs = (cy + CW'(128)) >>> 8;
        add_c = (SUM_W+2)'(sc_reg) + (SUM_W+2)'(rc);
        add_s = (SUM_W+2)'(ss_reg) + (SUM_W+2)'(rs);
        p32 = cz;
        pq = to_ang(p32);
        dlt = (ANGLE_WIDTH+1)'(pq) - (ANGLE_WIDTH+1)'(prev_reg);
        half = {p32[31], p32[31:1]};
    end

    // cordic operand setup
    logic signed [CW-1:0] vx, vy;
    logic [31:0] vz, ra, rz;
    logic signed [CW-1:0] rx;
    always_comb
    begin
        vx = (st_reg == S_BEND) ? (CW'(sc_reg) <<< 8) : (CW'(re_reg) <<< 8);
        vy = (st_reg == S_BEND) ? (CW'(ss_reg) <<< 8) : (CW'(im_reg) <<< 8);
        vz = 32'd0;
        if (vx < 0)
        begin
            vx = -vx;
            vy = -vy;
            vz = 32'h8000_0000;
        end
        ra = mode_reg ? vang : ((vang << 1) - {ref_reg, 16'd0});
        rx = ROT_START;
        rz = ra;
        if (!ra[31] && ra > 32'h4000_0000)
        begin
            rx = -ROT_START;
            rz = ra - 32'h8000_0000;
        end
        else if (ra[31] && ra < 32'hC000_0000)
        begin
            rx = -ROT_START;
            rz = ra + 32'h8000_0000;
        end
        cx_in = vx;
        cy_in = vy;
        cz_in = vz;
        if (st_reg == S_ROT)
        begin
            cx_in = rx;
            cy_in = '0;
            cz_in = rz;
        end
    end

    logic vzero;
    assign vzero = (re_reg == '0) && (im_reg == '0);

    // sequencer with a phase flag for the cordic passes
    logic [1:0] pass_reg, pass_next;
    localparam logic [1:0] P_NONE = 2'd0;
    localparam logic [1:0] P_VEC  = 2'd1;
    localparam logic [1:0] P_ROT  = 2'd2;
    localparam logic [1:0] P_BLK  = 2'd3;
    logic go_vec, go_rot, go_blk;

    always_comb
    begin
        st_next = st_reg;
        pass_next = pass_reg;
        ss_next = ss_reg;
        sc_next = sc_reg;
        cnt_next = cnt_reg;
        prev_next = prev_reg;
        par_next = par_reg;
        ph_next = ph_reg;
        err_next = err_reg;
        go_vec = 1'b0;
        go_rot = 1'b0;
        go_blk = 1'b0;
        cmd.start = 1'b0;
        cmd.op = OP_VEC;
        case (st_reg)
            S_IDLE:
                if (in_valid)
                    st_next = S_VEC1;
            S_VEC1:
            begin
                if (!use_smp)
                    st_next = S_ACC;
                else if (vzero)
                begin
                    // zero sample: angle 0 goes straight to rotation
                    pass_next = P_ROT;
                    st_next = S_ROT;
                end
                else
                begin
                    go_vec = 1'b1;
                    pass_next = P_VEC;
                    st_next = S_FIN;
                end
            end
            S_FIN:
                if (cdone)
                begin
                    if (pass_reg == P_VEC)
                        st_next = S_ROT;
                    else if (pass_reg == P_ROT)
                    begin
                        sc_next = sat(add_c);
                        ss_next = sat(add_s);
                        st_next = S_ACC;
                    end
                    else
                    begin
                        ss_next = '0;
                        sc_next = '0;
                        err_next = 1'b0;
                        if (mode_reg)
                            ph_next = 16'(pq);
                        else
                        begin
                            if (dlt > (ANGLE_WIDTH+1)'(1 << (ANGLE_WIDTH-1)) ||
                                dlt < -(ANGLE_WIDTH+1)'(1 << (ANGLE_WIDTH-1)))
                            begin
                                par_next = !par_reg;
                                ph_next = 16'(to_ang(!par_reg ? half + 32'h8000_0000 : half));
                            end
                            else
                                ph_next = 16'(to_ang(par_reg ? half + 32'h8000_0000 : half));
                            prev_next = pq;
                        end
                        st_next = S_OUT;
                    end
                end
            S_ROT:
            begin
                go_rot = 1'b1;
                pass_next = P_ROT;
                st_next = S_FIN;
            end
            S_ACC:
            begin
                if (!last_smp)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    st_next = S_IDLE;
                end
                else
                begin
                    cnt_next = '0;
                    st_next = S_BEND;
                end
            end
            S_BEND:
            begin
                if (sum_zero)
                begin
                    ph_next = 16'd0;
                    err_next = 1'b1;
                    st_next = S_OUT;
                end
                else
                begin
                    go_blk = 1'b1;
                    pass_next = P_BLK;
                    st_next = S_FIN;
                end
            end
            S_OUT:
                if (!out_stall)
                    st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
        if (go_vec || go_blk)
        begin
            cmd.start = 1'b1;
            cmd.op = OP_VEC;
        end
        if (go_rot)
        begin
            cmd.start = 1'b1;
            cmd.op = OP_ROT;
        end
    end

    // angle for a zero sample is zero: force it through the rotation input
    logic [31:0] vang_eff;
    logic [31:0] ang_reg;
    assign vang_eff = (pass_reg == P_VEC) ? cz : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            pass_reg <= P_NONE;
            ss_reg   <= '0;
            sc_reg   <= '0;
            cnt_reg  <= '0;
            prev_reg <= '0;
            par_reg  <= 1'b0;
            err_reg  <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            pass_reg <= pass_next;
            ss_reg   <= ss_next;
            sc_reg   <= sc_next;
            cnt_reg  <= cnt_next;
            prev_reg <= prev_next;
            par_reg  <= par_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ph_reg <= ph_next;
        if (st_reg == S_IDLE && in_valid)
        begin
            re_reg  <= sample_real[SAMPLE_WIDTH-1:0];
            im_reg  <= sample_imag[SAMPLE_WIDTH-1:0];
            ref_reg <= reference_phase;
            vld_reg <= reference_valid;
        end
        if (st_reg == S_FIN && cdone && pass_reg == P_VEC)
            ang_reg <= vang_eff;
        else if (st_reg == S_VEC1)
            ang_reg <= 32'd0;
    end

    assign vang = ang_reg;

    assign in_stall    = (st_reg != S_IDLE);
    assign out_valid   = (st_reg == S_OUT);
    assign phase       = ph_reg;
    assign block_error = err_reg;

`include "msk_block_phase_estimator_unit_assert.svh"
    `MBPE_ASSERT_IMP(a_out_has_no_input, clk, rst_n, out_valid, in_stall, "input taken while result waits")
    `MBPE_ASSERT_NEXT(a_err_zero, clk, rst_n, (st_reg == S_BEND) && sum_zero, block_error && phase == 16'd0, "error result not zero")
    `MBPE_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg < CNT_MAX, "block count past maximum length")

endmodule
`default_nettype wire
